// ===== rtl/satq_pkg.sv =====
// shared types and constants of the sorted alarm timer queue
package satq_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 16;
   localparam int MAX_OUT = 16;
   localparam int N_W = $clog2(MAX_OUT + 1);

   localparam int TIME_W = 32;
   localparam int EVENT_W = 16;
   localparam int MPT_W = 10;
   localparam logic [MPT_W-1:0] MPT_RESET = MPT_W'(10);

   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_TICK = 1'b1;

   typedef enum logic [1:0] {
      KIND_INSERTED = 2'd0,
      KIND_FULL     = 2'd1,
      KIND_EXPIRED  = 2'd2,
      KIND_NONE_DUE = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ADD,
      ST_INSERT,
      ST_POP
   } state_type;

   typedef struct packed {
      logic     load;
      logic     mul;
      logic     add;
      logic     insert;
      logic     pop;
      logic     emit;
      kind_type kind;
      logic     last;
   } cmd_type;

   typedef struct packed {
      logic is_tick;
      logic full;
      logic head_le;
      logic next_le;
   } sts_type;

endpackage

// ===== rtl/satq_dpath.sv =====
// datapath: input word registers, time arithmetic, sorted entry row, result payload
module satq_dpath #(
   parameter int QUEUE_DEPTH = satq_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  satq_pkg::cmd_type             cmd,
   output satq_pkg::sts_type             sts,
   input  logic                          req_action,
   input  logic [satq_pkg::TIME_W-1:0]   req_now_ticks,
   input  logic [satq_pkg::TIME_W-1:0]   req_delay_ms,
   input  logic [satq_pkg::EVENT_W-1:0]  req_event_id,
   input  logic                          csr_write,
   input  logic [satq_pkg::MPT_W-1:0]    csr_data,
   output logic [1:0]                    rsp_kind,
   output logic [satq_pkg::EVENT_W-1:0]  rsp_expired_event,
   output logic [satq_pkg::TIME_W-1:0]   rsp_wakeup_time,
   output logic                          rsp_last
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int PROD_W = satq_pkg::TIME_W + satq_pkg::MPT_W;

   logic                          action_ff;
   logic [satq_pkg::TIME_W-1:0]   ticks_ff;
   logic [satq_pkg::TIME_W-1:0]   delay_ff;
   logic [satq_pkg::EVENT_W-1:0]  event_ff;
   logic [satq_pkg::MPT_W-1:0]    mpt_ff;
   logic [satq_pkg::TIME_W-1:0]   now_ms_ff;
   logic [satq_pkg::TIME_W-1:0]   wake_ff;
   logic [CNT_W-1:0]              count_ff;
   logic [CNT_W-1:0]              count_in;

   logic [satq_pkg::TIME_W-1:0]   wq_ff [QUEUE_DEPTH];
   logic [satq_pkg::EVENT_W-1:0]  eq_ff [QUEUE_DEPTH];
   logic [satq_pkg::TIME_W-1:0]   wq_in [QUEUE_DEPTH];
   logic [satq_pkg::EVENT_W-1:0]  eq_in [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0]        gt;
   logic [QUEUE_DEPTH-1:0]        gt_prev;

   logic [PROD_W-1:0]             prod;

   logic [1:0]                    rsp_kind_ff;
   logic [satq_pkg::EVENT_W-1:0]  rsp_event_ff;
   logic [satq_pkg::TIME_W-1:0]   rsp_wake_ff;
   logic                          rsp_last_ff;

   assign prod = PROD_W'(ticks_ff) * PROD_W'(mpt_ff);

   // per-entry compare: new alarm goes behind entries strictly earlier
   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         gt[i] = (CNT_W'(i) < count_ff) && (wake_ff > wq_ff[i]);
      end
      gt_prev[0] = 1'b1;
      for (int i = 1; i < QUEUE_DEPTH; i++) begin
         gt_prev[i] = gt[i-1];
      end
   end

   always_comb begin
      count_in = count_ff;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         wq_in[i] = wq_ff[i];
         eq_in[i] = eq_ff[i];
      end
      if (cmd.insert) begin
         count_in = count_ff + CNT_W'(1);
         for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (gt[i]) begin
               wq_in[i] = wq_ff[i];
               eq_in[i] = eq_ff[i];
            end else if (gt_prev[i]) begin
               wq_in[i] = wake_ff;
               eq_in[i] = event_ff;
            end else begin
               wq_in[i] = wq_ff[(i == 0) ? 0 : i - 1];
               eq_in[i] = eq_ff[(i == 0) ? 0 : i - 1];
            end
         end
      end else if (cmd.pop) begin
         count_in = count_ff - CNT_W'(1);
         for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            wq_in[i] = wq_ff[i+1];
            eq_in[i] = eq_ff[i+1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         mpt_ff   <= satq_pkg::MPT_RESET;
      end else begin
         count_ff <= count_in;
         if (csr_write) begin
            mpt_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         wq_ff[i] <= wq_in[i];
         eq_ff[i] <= eq_in[i];
      end
      if (cmd.load) begin
         action_ff <= req_action;
         ticks_ff  <= req_now_ticks;
         delay_ff  <= req_delay_ms;
         event_ff  <= req_event_id;
      end
      if (cmd.mul) begin
         now_ms_ff <= prod[satq_pkg::TIME_W-1:0];
      end
      if (cmd.add) begin
         wake_ff <= now_ms_ff + delay_ff;
      end
      if (cmd.emit) begin
         rsp_kind_ff <= cmd.kind;
         rsp_last_ff <= cmd.last;
         unique case (cmd.kind)
            satq_pkg::KIND_INSERTED, satq_pkg::KIND_FULL: begin
               rsp_event_ff <= event_ff;
               rsp_wake_ff  <= wake_ff;
            end
            satq_pkg::KIND_EXPIRED: begin
               rsp_event_ff <= eq_ff[0];
               rsp_wake_ff  <= wq_ff[0];
            end
            default: begin
               rsp_event_ff <= '0;
               rsp_wake_ff  <= now_ms_ff;
            end
         endcase
      end
   end

   assign sts.is_tick = (action_ff == satq_pkg::ACT_TICK);
   assign sts.full    = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign sts.head_le = (count_ff != '0) && (wq_ff[0] <= now_ms_ff);
   assign sts.next_le = (count_ff > CNT_W'(1)) && (wq_ff[1] <= now_ms_ff);

   assign rsp_kind          = rsp_kind_ff;
   assign rsp_expired_event = rsp_event_ff;
   assign rsp_wakeup_time   = rsp_wake_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

// ===== rtl/satq_ctrl.sv =====
// controller: sequencing state machine, expiry counter and result valid
module satq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  satq_pkg::sts_type sts,
   output satq_pkg::cmd_type cmd
);

   satq_pkg::state_type       state_ff;
   satq_pkg::state_type       state_in;
   logic [satq_pkg::N_W-1:0]  n_ff;
   logic [satq_pkg::N_W-1:0]  n_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic                      out_free;
   logic                      due;
   logic                      more;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign due  = sts.head_le && (n_ff != satq_pkg::N_W'(satq_pkg::MAX_OUT));
   assign more = sts.next_le && (n_ff != satq_pkg::N_W'(satq_pkg::MAX_OUT - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         satq_pkg::ST_IDLE: begin
            if (req_valid) state_in = satq_pkg::ST_MUL;
         end
         satq_pkg::ST_MUL: begin
            state_in = sts.is_tick ? satq_pkg::ST_POP : satq_pkg::ST_ADD;
         end
         satq_pkg::ST_ADD: begin
            state_in = satq_pkg::ST_INSERT;
         end
         satq_pkg::ST_INSERT: begin
            if (out_free) state_in = satq_pkg::ST_IDLE;
         end
         satq_pkg::ST_POP: begin
            if (!due || !more) begin
               if (out_free || (!due && n_ff != '0)) state_in = satq_pkg::ST_IDLE;
            end
         end
         default: state_in = satq_pkg::ST_IDLE;
      endcase
   end

   // command outputs
   always_comb begin
      cmd      = '0;
      cmd.kind = satq_pkg::KIND_INSERTED;
      unique case (state_ff)
         satq_pkg::ST_IDLE: begin
            cmd.load = req_valid;
         end
         satq_pkg::ST_MUL: begin
            cmd.mul = 1'b1;
         end
         satq_pkg::ST_ADD: begin
            cmd.add = 1'b1;
         end
         satq_pkg::ST_INSERT: begin
            if (out_free) begin
               cmd.emit   = 1'b1;
               cmd.last   = 1'b1;
               cmd.insert = !sts.full;
               cmd.kind   = sts.full ? satq_pkg::KIND_FULL : satq_pkg::KIND_INSERTED;
            end
         end
         satq_pkg::ST_POP: begin
            if (out_free) begin
               if (due) begin
                  cmd.emit = 1'b1;
                  cmd.pop  = 1'b1;
                  cmd.kind = satq_pkg::KIND_EXPIRED;
                  cmd.last = !more;
               end else if (n_ff == '0) begin
                  cmd.emit = 1'b1;
                  cmd.kind = satq_pkg::KIND_NONE_DUE;
                  cmd.last = 1'b1;
               end
            end
         end
         default: begin
            cmd.load = 1'b0;
         end
      endcase
   end

   always_comb begin
      n_in = n_ff;
      if (state_ff == satq_pkg::ST_MUL) begin
         n_in = '0;
      end else if (cmd.pop) begin
         n_in = n_ff + satq_pkg::N_W'(1);
      end
      rsp_valid_in = cmd.emit || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= satq_pkg::ST_IDLE;
         n_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         n_ff         <= n_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != satq_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/sorted_alarm_timer_queue_top.sv =====
// top level of the sorted alarm timer queue
// insert: word taken in idle, then multiply, add, insert; the result goes into the output
//   register in insert (held while the output stalls), then back to idle for the next word
// tick: word taken, multiply, then one expired alarm per unstalled cycle (up to 16) or one
//   nothing-due word; the single 32x10 multiplier and the one-word output register set the pace
// reset (synchronous, active high) empties the queue and sets ms_per_tick to 10
module sorted_alarm_timer_queue_top #(
   parameter int QUEUE_DEPTH = satq_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_action,
   input  logic [satq_pkg::TIME_W-1:0]   req_now_ticks,
   input  logic [satq_pkg::TIME_W-1:0]   req_delay_ms,
   input  logic [satq_pkg::EVENT_W-1:0]  req_event_id,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_kind,
   output logic [satq_pkg::EVENT_W-1:0]  rsp_expired_event,
   output logic [satq_pkg::TIME_W-1:0]   rsp_wakeup_time,
   output logic                          rsp_last,
   // ms_per_tick register write
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [satq_pkg::MPT_W-1:0]    csr_data
);

   satq_pkg::cmd_type cmd;
   satq_pkg::sts_type sts;

   // register write is always taken
   assign csr_ready = 1'b1;

   // sequencing and handshakes
   satq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // sorted entry row, time math and response payload
   satq_dpath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_action        (req_action),
      .req_now_ticks     (req_now_ticks),
      .req_delay_ms      (req_delay_ms),
      .req_event_id      (req_event_id),
      .csr_write         (csr_valid && csr_ready),
      .csr_data          (csr_data),
      .rsp_kind          (rsp_kind),
      .rsp_expired_event (rsp_expired_event),
      .rsp_wakeup_time   (rsp_wakeup_time),
      .rsp_last          (rsp_last)
   );

endmodule

// ===== dv/tb_sorted_alarm_timer_queue_top.sv =====
// testbench for the sorted alarm timer queue: predicted alarm words checked in order

typedef struct packed {
   satq_pkg::kind_type           kind;
   logic [satq_pkg::EVENT_W-1:0] event_id;
   logic [satq_pkg::TIME_W-1:0]  wake;
   logic                         last;
} alarm_word_type;

// shadow copy of the alarm queue plus the words it is owed
class alarm_queue_tracker;
   logic [satq_pkg::TIME_W-1:0]  shadow_wake [satq_pkg::QUEUE_DEPTH_DEFAULT];
   logic [satq_pkg::EVENT_W-1:0] shadow_event [satq_pkg::QUEUE_DEPTH_DEFAULT];
   int                           shadow_count;
   logic [satq_pkg::MPT_W-1:0]   ms_per_tick;
   alarm_word_type               awaited_words [$];
   int                           mismatches;

   function new();
      shadow_count = 0;
      ms_per_tick = satq_pkg::MPT_RESET;
      mismatches = 0;
   endfunction

   function int awaited();
      return awaited_words.size();
   endfunction

   function void push_word(satq_pkg::kind_type kind, logic [15:0] ev, logic [31:0] wake,
                           logic last);
      alarm_word_type w;
      w.kind = kind;
      w.event_id = ev;
      w.wake = wake;
      w.last = last;
      awaited_words.push_back(w);
   endfunction

   // an accepted request word: update the shadow queue, queue the words it causes
   function void note_request(logic act, logic [31:0] ticks, logic [31:0] delay,
                              logic [15:0] ev);
      logic [31:0] now_ms;
      logic [31:0] wake;
      int          pos;
      int          n_due;
      now_ms = ticks * 32'(ms_per_tick);
      if (act == satq_pkg::ACT_INSERT) begin
         wake = now_ms + delay;
         if (shadow_count >= satq_pkg::QUEUE_DEPTH_DEFAULT) begin
            push_word(satq_pkg::KIND_FULL, ev, wake, 1'b1);
         end else begin
            // new alarm goes ahead of equal wakeups
            pos = 0;
            while (pos < shadow_count && wake > shadow_wake[pos])
               pos++;
            for (int i = shadow_count; i > pos; i--) begin
               shadow_wake[i] = shadow_wake[i-1];
               shadow_event[i] = shadow_event[i-1];
            end
            shadow_wake[pos] = wake;
            shadow_event[pos] = ev;
            shadow_count++;
            push_word(satq_pkg::KIND_INSERTED, ev, wake, 1'b1);
         end
      end else begin
         n_due = 0;
         while (n_due < shadow_count && n_due < satq_pkg::MAX_OUT &&
                shadow_wake[n_due] <= now_ms)
            n_due++;
         if (n_due == 0) begin
            push_word(satq_pkg::KIND_NONE_DUE, '0, now_ms, 1'b1);
         end else begin
            for (int i = 0; i < n_due; i++)
               push_word(satq_pkg::KIND_EXPIRED, shadow_event[i], shadow_wake[i],
                         i == n_due - 1);
            for (int i = n_due; i < shadow_count; i++) begin
               shadow_wake[i-n_due] = shadow_wake[i];
               shadow_event[i-n_due] = shadow_event[i];
            end
            shadow_count -= n_due;
         end
      end
   endfunction

   task report_mismatch(string what);
      mismatches++;
      $display("%0t: %s", $time, what);
   endtask

   task check_word(logic [1:0] kind, logic [15:0] ev, logic [31:0] wake, logic last);
      alarm_word_type want;
      if (awaited_words.size() == 0) begin
         report_mismatch($sformatf("word with nothing awaited: kind %0d event %h wake %h",
                                   kind, ev, wake));
         return;
      end
      want = awaited_words.pop_front();
      if (kind !== want.kind)
         report_mismatch($sformatf("kind %0d, want %0d", kind, want.kind));
      if (ev !== want.event_id)
         report_mismatch($sformatf("event %h, want %h", ev, want.event_id));
      if (wake !== want.wake)
         report_mismatch($sformatf("wakeup %h, want %h", wake, want.wake));
      if (last !== want.last)
         report_mismatch($sformatf("last %b, want %b", last, want.last));
   endtask
endclass

module tb_sorted_alarm_timer_queue_top;

   // no acceptance on any channel for this long means the block is stuck
   localparam int QUIET_LIMIT = 2000;
   localparam int N_PHASES = 5;
   localparam int ITEMS_PER_PHASE = 52;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic                          req_action;
   logic [satq_pkg::TIME_W-1:0]   req_now_ticks;
   logic [satq_pkg::TIME_W-1:0]   req_delay_ms;
   logic [satq_pkg::EVENT_W-1:0]  req_event_id;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [1:0]                    rsp_kind;
   logic [satq_pkg::EVENT_W-1:0]  rsp_expired_event;
   logic [satq_pkg::TIME_W-1:0]   rsp_wakeup_time;
   logic                          rsp_last;
   logic                          csr_valid;
   logic                          csr_ready;
   logic [satq_pkg::MPT_W-1:0]    csr_data;

   int send_idle_pct = 24;
   int recv_idle_pct = 65;
   int quiet_cycles = 0;

   alarm_queue_tracker sb = new();

   sorted_alarm_timer_queue_top uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_now_ticks     (req_now_ticks),
      .req_delay_ms      (req_delay_ms),
      .req_event_id      (req_event_id),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_expired_event (rsp_expired_event),
      .rsp_wakeup_time   (rsp_wakeup_time),
      .rsp_last          (rsp_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_data          (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // response side: check each accepted word, stall at random, and watch for a hang
   always @(posedge clock) begin
      if (rsp_valid === 1'b1 && rsp_stall == 1'b0)
         sb.check_word(rsp_kind, rsp_expired_event, rsp_wakeup_time, rsp_last);
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);

      if (reset || (req_valid && req_stall === 1'b0) ||
          (rsp_valid === 1'b1 && !rsp_stall) || (csr_valid && csr_ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // one request word: optional random gap, then hold it until the block takes it
   task automatic send_word(input logic act, input logic [31:0] ticks,
                            input logic [31:0] delay, input logic [15:0] ev);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_now_ticks <= ticks;
      req_delay_ms <= delay;
      req_event_id <= ev;
      @(posedge clock);
      while (req_stall !== 1'b0)
         @(posedge clock);
      sb.note_request(act, ticks, delay, ev);
   endtask

   // sender holds off until every awaited word has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.awaited() != 0)
         @(posedge clock);
   endtask

   // only called with the block idle
   task automatic write_ms_per_tick(input logic [satq_pkg::MPT_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (csr_ready !== 1'b1)
         @(posedge clock);
      csr_valid <= 1'b0;
      sb.ms_per_tick = value;
   endtask

   task automatic set_idle_mode(input int phase);
      // sender light / receiver heavy, then swapped, then no idling at all
      if (phase < 2) begin
         send_idle_pct = 24;
         recv_idle_pct = 65;
      end else if (phase < 4) begin
         send_idle_pct = 65;
         recv_idle_pct = 24;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
   endtask

   // directed: empty tick, ties, a full queue, a full-width expiry burst, time extremes
   task automatic run_directed();
      send_word(satq_pkg::ACT_TICK, 32'd0, 32'd0, 16'd0);
      send_word(satq_pkg::ACT_INSERT, 32'd0, 32'd0, 16'hFFFF);
      send_word(satq_pkg::ACT_INSERT, 32'd0, 32'd0, 16'h0001);
      for (int i = 0; i < 14; i++)
         send_word(satq_pkg::ACT_INSERT, 32'(i), 32'($urandom_range(0, 40)),
                   16'(16'h0100 + i));
      // one more than the queue holds
      send_word(satq_pkg::ACT_INSERT, 32'd3, 32'd7, 16'hABCD);
      // every entry is due: the largest burst one tick can give
      send_word(satq_pkg::ACT_TICK, 32'd1000, 32'd0, 16'd0);
      // wakeup arithmetic wraps at the top of the range
      send_word(satq_pkg::ACT_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h8000);
      send_word(satq_pkg::ACT_INSERT, 32'd0, 32'hFFFF_FFFF, 16'h0000);
      send_word(satq_pkg::ACT_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
      // a pending alarm that is not yet due
      send_word(satq_pkg::ACT_TICK, 32'd0, 32'd0, 16'd0);
   endtask

   // mostly a moving clock with near-term alarms, some bursts that fill the queue,
   // a little noise over the full field ranges
   task automatic run_random(input int count);
      logic [31:0] cur_ticks;
      int          burst_left;
      int          roll;
      cur_ticks = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFE0 : 32'($urandom_range(0, 500));
      burst_left = 0;
      for (int k = 0; k < count; k++) begin
         if ($urandom_range(0, 99) < 4)
            wait_drained();
         if (burst_left == 0 && $urandom_range(0, 29) == 0)
            burst_left = $urandom_range(8, 17);
         roll = $urandom_range(0, 99);
         if (burst_left != 0) begin
            burst_left--;
            send_word(satq_pkg::ACT_INSERT, cur_ticks, 32'($urandom_range(0, 200)),
                      16'($urandom));
         end else if (roll < 8) begin
            send_word(1'($urandom_range(0, 1)), $urandom, $urandom, 16'($urandom));
         end else if (roll < 58) begin
            send_word(satq_pkg::ACT_INSERT, cur_ticks,
                      32'($urandom_range(0, 6 * int'(sb.ms_per_tick) + 20)),
                      16'($urandom));
         end else begin
            cur_ticks = cur_ticks + 32'($urandom_range(0, 4));
            send_word(satq_pkg::ACT_TICK, cur_ticks, $urandom, 16'($urandom));
         end
      end
   endtask

   initial begin
      logic [satq_pkg::MPT_W-1:0] phase_mpt [N_PHASES];
      phase_mpt[0] = 10'd1000;
      phase_mpt[1] = 10'd0;
      phase_mpt[2] = 10'd1023;
      phase_mpt[3] = 10'd1;
      phase_mpt[4] = 10'($urandom_range(1, 1000));

      reset <= 1'b1;
      req_valid <= 1'b0;
      req_action <= satq_pkg::ACT_INSERT;
      req_now_ticks <= '0;
      req_delay_ms <= '0;
      req_event_id <= '0;
      csr_valid <= 1'b0;
      csr_data <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed part runs at the reset value of ms_per_tick
      set_idle_mode(0);
      run_directed();
      for (int p = 0; p < N_PHASES; p++) begin
         wait_drained();
         write_ms_per_tick(phase_mpt[p]);
         set_idle_mode(p + 1);
         run_random(ITEMS_PER_PHASE);
      end

      wait_drained();
      // give any stray word time to show up
      repeat (30) @(posedge clock);
      if (sb.awaited() != 0)
         sb.report_mismatch($sformatf("%0d words never arrived", sb.awaited()));
      if (sb.mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/satq_pkg.sv
rtl/satq_dpath.sv
rtl/satq_ctrl.sv
rtl/sorted_alarm_timer_queue_top.sv
dv/tb_sorted_alarm_timer_queue_top.sv
